FILE: hw/rtl/spgr_pkg.sv
// Shared types and constants for the stepper pulse generator.
`default_nettype none
package spgr_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 24;

   localparam int POS_W   = 16;
   localparam int DELAY_W = 24;
   localparam int STEPS_W = 16;

   localparam logic [POS_W-1:0]   STEPS_PER_TURN_RST = 16'd200;
   localparam logic [DELAY_W-1:0] CONST_DELAY_RST    = 24'd1000;

   typedef enum logic [REQ_TUSER_W-1:0] {
      MODE_LOAD  = 2'd0,
      MODE_START = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEPS_PER_TURN = 1'b0,
      CSR_CONST_DELAY    = 1'b1
   } csr_index_type;

endpackage
`default_nettype wire

FILE: hw/rtl/stepper_pulse_generator_ramp.sv
// Step pulse generator with constant or table-driven step delay.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  req     | req_tvalid/req_tready | tuser: mode; tdata: table/move/limit fields
//  rsp     | rsp_tvalid/rsp_tready | tdata: pulse, direction, position, status
//  csr     | csr_we                | csr_index, csr_wdata
//
// Each transfer is worked in the cycle it is accepted; its result is held in
// the output register and shows in the next cycle. One item per cycle while the output register is empty or taken.
// The delay table read for the next item is registered at the same edge, so
// a table word is ready for the tick that follows any load, start or step.
// reset is synchronous; it clears the control state and loads the CSR defaults; the table is not cleared.
// A stalled result holds; req_tready stays high while the result is taken.
`default_nettype none
module stepper_pulse_generator_ramp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [7:0] table_index, [31:8] table_value, [47:32] move_steps,
   // [48] use_ramp, [49] limit_cw_low, [50] limit_ccw_low, [55:51] zero
   input  wire logic [spgr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] mode
   input  wire logic [spgr_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] step_pulse, [1] direction_level, [17:2] position, [18] busy_res,
   // [19] motor_enable, [23:20] zero
   output logic [spgr_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [spgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [spgr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import spgr_pkg::*;

   localparam logic [TBL_AW-1:0] RAMP_LAST = TBL_AW'(TABLE_DEPTH - 1);

   // input fields
   logic [7:0]          tbl_index;
   logic [DELAY_W-1:0]  tbl_value;
   logic [STEPS_W-1:0]  move_steps;
   logic                use_ramp;
   logic                limit_cw_low;
   logic                limit_ccw_low;

   // state
   logic [DELAY_W-1:0]  elapsed_ff, elapsed_in;
   logic [STEPS_W-1:0]  steps_ff, steps_in;
   logic [TBL_AW-1:0]   ramp_idx_ff, ramp_idx_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                dir_ff, dir_in;
   logic                ramp_on_ff, ramp_on_in;
   logic                enable_ff, enable_in;
   logic                dir_line_ff, dir_line_in;
   logic [POS_W-1:0]    spt_ff;
   logic [DELAY_W-1:0]  const_delay_ff;

   // table memory
   logic [DELAY_W-1:0]  delay_mem [TABLE_DEPTH];
   logic [DELAY_W-1:0]  rd_data_ff;
   logic [DELAY_W-1:0]  wr_data_ff;
   logic                wr_hit_ff;
   logic                tbl_we;
   logic [TBL_AW-1:0]   tbl_waddr;

   // output register
   logic                rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic                accept;
   logic [DELAY_W-1:0]  elapsed_inc;
   logic [DELAY_W-1:0]  cur_delay;
   logic                step_go;
   logic [POS_W-1:0]    pos_adv;
   logic [POS_W-1:0]    pos_plus;
   logic                pulse;

   assign tbl_index     = req_tdata[7:0];
   assign tbl_value     = req_tdata[31:8];
   assign move_steps    = req_tdata[47:32];
   assign use_ramp      = req_tdata[48];
   assign limit_cw_low  = req_tdata[49];
   assign limit_ccw_low = req_tdata[50];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign elapsed_inc = (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign cur_delay   = ramp_on_ff ? (wr_hit_ff ? wr_data_ff : rd_data_ff)
                                   : const_delay_ff;
   assign step_go     = (steps_ff != '0) && (elapsed_inc >= cur_delay);

   // position wrap modulo steps_per_turn; zero modulus wraps at full width
   assign pos_plus = pos_ff + 1'b1;
   always_comb begin
      if (dir_ff) begin
         if ((spt_ff != '0) && (pos_plus >= spt_ff)) begin
            pos_adv = '0;
         end else begin
            pos_adv = pos_plus;
         end
      end else begin
         if ((pos_ff == '0) || ((spt_ff != '0) && (pos_ff >= spt_ff))) begin
            pos_adv = spt_ff - 1'b1;
         end else begin
            pos_adv = pos_ff - 1'b1;
         end
      end
   end

   always_comb begin
      elapsed_in  = elapsed_ff;
      steps_in    = steps_ff;
      ramp_idx_in = ramp_idx_ff;
      pos_in      = pos_ff;
      dir_in      = dir_ff;
      ramp_on_in  = ramp_on_ff;
      enable_in   = enable_ff;
      dir_line_in = dir_line_ff;
      pulse       = 1'b0;
      tbl_we      = 1'b0;
      tbl_waddr   = TBL_AW'(tbl_index);
      if (accept) begin
         case (mode_type'(req_tuser))
            MODE_LOAD: begin
               tbl_we = (32'(tbl_index) < TABLE_DEPTH);
            end
            MODE_START: begin
               if (move_steps != '0) begin
                  dir_in = !move_steps[STEPS_W-1];
               end
               steps_in    = move_steps[STEPS_W-1] ? (~move_steps + 1'b1) : move_steps;
               enable_in   = 1'b1;
               ramp_on_in  = use_ramp;
               ramp_idx_in = '0;
            end
            MODE_TICK: begin
               elapsed_in = elapsed_inc;
               if (step_go) begin
                  elapsed_in = '0;
                  pos_in     = pos_adv;
                  steps_in   = steps_ff - 1'b1;
                  if (ramp_on_ff && (ramp_idx_ff < RAMP_LAST)) begin
                     ramp_idx_in = ramp_idx_ff + 1'b1;
                  end
                  pulse = dir_ff ? limit_cw_low : limit_ccw_low;
                  if (pulse) begin
                     dir_line_in = dir_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff  <= '0;
         steps_ff    <= '0;
         ramp_idx_ff <= '0;
         pos_ff      <= '0;
         dir_ff      <= 1'b0;
         ramp_on_ff  <= 1'b0;
         enable_ff   <= 1'b0;
         dir_line_ff <= 1'b0;
         wr_hit_ff   <= 1'b0;
      end else begin
         elapsed_ff  <= elapsed_in;
         steps_ff    <= steps_in;
         ramp_idx_ff <= ramp_idx_in;
         pos_ff      <= pos_in;
         dir_ff      <= dir_in;
         ramp_on_ff  <= ramp_on_in;
         enable_ff   <= enable_in;
         dir_line_ff <= dir_line_in;
         // forward a load that lands on the entry being read
         wr_hit_ff   <= tbl_we && (tbl_waddr == ramp_idx_in);
      end
   end

   // delay table: one write port, one registered read at the next ramp index
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         delay_mem[tbl_waddr] <= tbl_value;
      end
      rd_data_ff <= delay_mem[ramp_idx_in];
      wr_data_ff <= tbl_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff         <= STEPS_PER_TURN_RST;
         const_delay_ff <= CONST_DELAY_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STEPS_PER_TURN: spt_ff         <= csr_wdata[POS_W-1:0];
            CSR_CONST_DELAY:    const_delay_ff <= csr_wdata[DELAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {4'b0000, enable_in, (steps_in != '0), pos_in,
                         dir_line_in, pulse};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/spgr_checker.sv
// Port-level checks for the stepper pulse generator, bound to the top level.
`default_nettype none
module spgr_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_tvalid,
   input wire logic                               req_tready,
   input wire logic [spgr_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input wire logic [spgr_pkg::REQ_TUSER_W-1:0]   req_tuser,
   input wire logic                               rsp_tvalid,
   input wire logic                               rsp_tready,
   input wire logic [spgr_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input wire logic                               csr_we,
   input wire logic [spgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input wire logic [spgr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import spgr_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // input side only backs up behind a waiting result
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output register");

   // every transfer in gives a result next cycle
   a_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result");

   // pulses come only from ticks
   a_pulse_tick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != MODE_TICK) |=> !rsp_tdata[0])
      else $error("step pulse on a non-tick item");

   // a nonzero start leaves the motor enabled and busy
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_START) &&
      (req_tdata[47:32] != 16'd0) |=> rsp_tdata[18] && rsp_tdata[19])
      else $error("start did not set busy and enable");

endmodule

bind stepper_pulse_generator_ramp spgr_checker u_spgr_checker (.*);
`default_nettype wire
